// File: rtl/adc_channel_window_stats_core_macros.svh
// ----------------------------------------------------------------------------
// ADC channel window statistics: assertion macros
// Shorthand for clocked implication properties, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ADC_CHANNEL_WINDOW_STATS_CORE_MACROS_SVH
`define ADC_CHANNEL_WINDOW_STATS_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acws assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ACWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acws assertion failed");

`endif

// File: rtl/acws_pkg.sv
// ----------------------------------------------------------------------------
// ADC channel window statistics: package
// Field widths, operation, filter and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package acws_pkg;

    localparam int OP_W      = 2;
    localparam int CHANNEL_W = 4;
    localparam int SAMPLE_W  = 8;
    localparam int FILTER_W  = 3;
    localparam int VALUE_W   = 8;
    localparam int STATUS_W  = 2;

    localparam int DEF_HISTORY_DEPTH = 8;
    localparam int DEF_CHANNEL_COUNT = 8;

    localparam logic [OP_W-1:0] OP_STORE = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [FILTER_W-1:0] FLT_LATEST  = 3'd0;
    localparam logic [FILTER_W-1:0] FLT_MEAN    = 3'd1;
    localparam logic [FILTER_W-1:0] FLT_WIN_MAX = 3'd2;
    localparam logic [FILTER_W-1:0] FLT_WIN_MIN = 3'd3;
    localparam logic [FILTER_W-1:0] FLT_MAX_CLR = 3'd4;
    localparam logic [FILTER_W-1:0] FLT_MIN_CLR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_FILTER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 2'd2;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 8'd0;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 8'd255;

endpackage

// File: rtl/acws_if.sv
// ----------------------------------------------------------------------------
// ADC channel window statistics: stream interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface acws_in_if;
    import acws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
    logic [FILTER_W-1:0]  filter;

    modport source (output valid, output op, output channel, output sample,
                    output filter, input ready);
    modport sink   (input valid, input op, input channel, input sample,
                    input filter, output ready);
endinterface

interface acws_out_if;
    import acws_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// File: rtl/adc_channel_window_stats_core.sv
// ----------------------------------------------------------------------------
// ADC channel window statistics core
// Per-channel sample ring, latest value and running extremes, with queries.
// ----------------------------------------------------------------------------
// Each request item is taken only while the sequencer is idle, so items are
// handled one at a time. A store or a clear keeps the block busy in the
// execute state after acceptance, and an op code of three is dropped
// on acceptance, so the next item may follow in the very next cycle. An
// invalid channel, and a query of the latest value or of an extreme since
// clear, keep the block busy in the execute and then the done state after
// acceptance. A query of the window mean, maximum or minimum walks the
// channel's ring through the single read port of the history memory, one
// entry a cycle, using one shared adder and comparator pair, and then scales
// the sum with one constant multiplication: such an item passes through the
// execute, scan, drain, mean and done states in turn. A finished result
// is held in an output register, so the next item may be accepted while it
// waits to be taken; a further result waits in the sequencer, with the input
// held off, for as long as the output register is still occupied. The
// history memory needs no clearing pass after reset: each channel keeps a
// fill flag alongside its write pointer, and ring entries that have never
// been written read as zero.
module adc_channel_window_stats_core #(
    parameter int HISTORY_DEPTH = acws_pkg::DEF_HISTORY_DEPTH,
    parameter int CHANNEL_COUNT = acws_pkg::DEF_CHANNEL_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acws_in_if.sink     i_in,
    acws_out_if.source  o_out
);
    import acws_pkg::*;

    // Widths that follow from the parameters.
    localparam int IDX_W     = $clog2(HISTORY_DEPTH);
    localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MEM_DEPTH = CHANNEL_COUNT * HISTORY_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = $clog2(HISTORY_DEPTH * 255 + 1);

    // The mean is the sum times a rounded-up reciprocal of the depth. With the
    // shift set to the sum width plus the ceiling log of the depth, the
    // product's upper part equals the truncated quotient for every sum.
    localparam int DIV_SH = SUM_W + IDX_W;
    localparam int MUL_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((64'd1 << DIV_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

    localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CHANNEL_W-1:0] CH_HIGHEST = CHANNEL_W'(CHANNEL_COUNT);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_MEAN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    // Captured request item.
    logic [OP_W-1:0]      r_op;
    logic [CHANNEL_W-1:0] r_channel;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [FILTER_W-1:0]  r_filter;

    // Per-channel state, each read at the one captured channel.
    logic [IDX_W-1:0]   r_wp     [CHANNEL_COUNT];
    logic               r_full   [CHANNEL_COUNT];
    logic [VALUE_W-1:0] r_latest [CHANNEL_COUNT];
    logic [VALUE_W-1:0] r_min    [CHANNEL_COUNT];
    logic [VALUE_W-1:0] r_max    [CHANNEL_COUNT];

    // History memory, one row of HISTORY_DEPTH entries per channel.
    logic [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_pend;
    logic                r_rd_live;

    // Window walk accumulators and the scaled sum.
    logic [IDX_W-1:0]   r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [VALUE_W-1:0] r_hi;
    logic [VALUE_W-1:0] r_lo;
    logic [PROD_W-1:0]  r_prod;

    // Pending result and its source.
    logic                r_win;
    logic [VALUE_W-1:0]  r_res_value;
    logic [STATUS_W-1:0] r_res_status;

    // Output register.
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    logic                ch_ok;
    logic [CH_W-1:0]     ch;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [VALUE_W-1:0]  acc_v;
    logic                out_free;
    logic [VALUE_W-1:0]  win_value;
    logic [VALUE_W-1:0]  done_value;

    assign ch_ok = (r_channel != '0) && (r_channel <= CH_HIGHEST);
    assign ch    = CH_W'(r_channel - CHANNEL_W'(1));

    // The product is exact modulo the address width, which is all that is kept.
    assign base    = ADDR_W'(ch) * ADDR_W'(HISTORY_DEPTH);
    assign wr_addr = base + ADDR_W'(r_wp[ch]);
    assign rd_addr = base + ADDR_W'(r_idx);
    assign mem_we  = (r_state == S_EXEC) && ch_ok && (r_op == OP_STORE);

    // Entries beyond the fill point have never been written and count as zero.
    assign acc_v = r_rd_live ? r_rd_data : VALUE_MIN;

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        case (r_filter)
            FLT_MEAN:    win_value = r_prod[DIV_SH +: VALUE_W];
            FLT_WIN_MAX: win_value = r_hi;
            default:     win_value = r_lo;
        endcase
    end

    assign done_value = r_win ? win_value : r_res_value;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

    // History memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_sample;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_live <= r_full[ch] || (r_idx < r_wp[ch]);
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_wp[c]     <= '0;
                r_full[c]   <= 1'b0;
                r_latest[c] <= VALUE_MIN;
                r_min[c]    <= VALUE_MAX;
                r_max[c]    <= VALUE_MIN;
            end
        end else begin
            r_rd_pend <= (r_state == S_SCAN);

            // A new result enters the output register as the old one leaves.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && (i_in.op != OP_NONE)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!ch_ok) begin
                        r_win        <= 1'b0;
                        r_res_value  <= VALUE_MIN;
                        r_res_status <= ST_BAD_CHANNEL;
                        r_state      <= S_DONE;
                    end else if (r_op == OP_STORE) begin
                        r_latest[ch] <= r_sample;
                        if (r_sample > r_max[ch]) begin
                            r_max[ch] <= r_sample;
                        end
                        if (r_sample < r_min[ch]) begin
                            r_min[ch] <= r_sample;
                        end
                        if (r_wp[ch] == IDX_LAST) begin
                            r_wp[ch]   <= '0;
                            r_full[ch] <= 1'b1;
                        end else begin
                            r_wp[ch] <= r_wp[ch] + IDX_W'(1);
                        end
                        r_state <= S_IDLE;
                    end else if (r_op == OP_CLEAR) begin
                        r_min[ch] <= VALUE_MAX;
                        r_max[ch] <= VALUE_MIN;
                        r_state   <= S_IDLE;
                    end else begin
                        case (r_filter)
                            FLT_LATEST: begin
                                r_win        <= 1'b0;
                                r_res_value  <= r_latest[ch];
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                            FLT_MAX_CLR: begin
                                r_win        <= 1'b0;
                                r_res_value  <= r_max[ch];
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                            FLT_MIN_CLR: begin
                                r_win        <= 1'b0;
                                r_res_value  <= r_min[ch];
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                            FLT_MEAN, FLT_WIN_MAX, FLT_WIN_MIN: begin
                                r_win        <= 1'b1;
                                r_res_status <= ST_OK;
                                r_state      <= S_SCAN;
                            end
                            default: begin
                                r_win        <= 1'b0;
                                r_res_value  <= VALUE_MIN;
                                r_res_status <= ST_BAD_FILTER;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: captured item, walk counter, accumulators, result.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op      <= i_in.op;
            r_channel <= i_in.channel;
            r_sample  <= i_in.sample;
            r_filter  <= i_in.filter;
        end

        if (r_state == S_EXEC) begin
            r_idx <= '0;
            r_sum <= '0;
            r_hi  <= VALUE_MIN;
            r_lo  <= VALUE_MAX;
        end else begin
            if (r_state == S_SCAN) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            // The shared unit: one add and two compares per ring entry.
            if (r_rd_pend) begin
                r_sum <= r_sum + SUM_W'(acc_v);
                if (acc_v > r_hi) begin
                    r_hi <= acc_v;
                end
                if (acc_v < r_lo) begin
                    r_lo <= acc_v;
                end
            end
        end

        if (r_state == S_MEAN) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(MEAN_MUL);
        end

        if ((r_state == S_DONE) && out_free) begin
            r_out_value  <= done_value;
            r_out_status <= r_res_status;
        end
    end

endmodule

// File: rtl/acws_checker.sv
// ----------------------------------------------------------------------------
// ADC channel window statistics: port checker
// Concurrent assertions on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`include "adc_channel_window_stats_core_macros.svh"

module acws_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [acws_pkg::OP_W-1:0]     i_in_op,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [acws_pkg::VALUE_W-1:0]  i_out_value,
    input logic [acws_pkg::STATUS_W-1:0] i_out_status
);
    import acws_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // A stalled result stays offered and unchanged.
    `ACWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_value) && $stable(i_out_status))

    // Any error result carries a zero value.
    `ACWS_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, i_out_valid && (i_out_status != ST_OK), i_out_value == VALUE_MIN)

    // A real operation keeps the sequencer busy for the following cycle.
    `ACWS_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, in_acc && (i_in_op != OP_NONE), !i_in_ready)

    // No result can be produced in the very cycle after an item is taken.
    `ACWS_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, in_acc, !$rose(i_out_valid))

endmodule

bind adc_channel_window_stats_core acws_checker u_acws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.op),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value),
    .i_out_status (o_out.status)
);
